// ===== hw/rtl/pap_two_level_branch_predictor_macros.svh =====
// assertion helpers used by the checker file
`ifndef PAP_TWO_LEVEL_BRANCH_PREDICTOR_MACROS_SVH
`define PAP_TWO_LEVEL_BRANCH_PREDICTOR_MACROS_SVH

// same-cycle implication, off while reset is low
`define PAP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pap2l check failed");

// next-cycle implication, off while reset is low
`define PAP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pap2l check failed");

// next-cycle implication that also holds through reset
`define PAP_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pap2l check failed");

`endif

// ===== hw/rtl/pap2l_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pap2l_pkg;

  // sizing
  localparam int HISTORY_BITS = 8;
  localparam int SLOTS        = 16;
  localparam int PATTERNS     = 1 << HISTORY_BITS;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int USED_W       = $clog2(SLOTS + 1);
  localparam int CTR_AW       = SLOT_W + HISTORY_BITS;
  localparam int CTR_DEPTH    = SLOTS * PATTERNS;

  // counter and total constants
  localparam logic [1:0]  CTR_INIT = 2'd2;
  localparam logic [1:0]  CTR_MAX  = 2'd3;
  localparam logic [1:0]  CTR_MIN  = 2'd0;
  localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] branch_address;
    logic        taken;
  } in_item_t;

  typedef struct packed {
    logic        predicted_taken;
    logic        correct;
    logic        newly_allocated;
    logic        untracked;
    logic [31:0] correct_total;
    logic [31:0] branch_total;
  } out_item_t;

  // slot lookup of the item in the input register
  typedef struct packed {
    logic              valid;
    logic              untracked;
    logic              fresh;
    logic              taken;
    logic [CTR_AW-1:0] idx;
  } lookup_t;

  // prediction outcome of the item in the counter stage
  typedef struct packed {
    logic valid;
    logic untracked;
    logic fresh;
    logic pred;
    logic ok;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pap2l_slot_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pap2l_slot_table (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                item_valid,
  input  wire pap2l_pkg::in_item_t item,
  output pap2l_pkg::lookup_t       lookup
);

  logic [31:0]                        slot_addr_r [pap2l_pkg::SLOTS];
  logic [pap2l_pkg::SLOTS-1:0]        slot_valid_r;
  logic [pap2l_pkg::HISTORY_BITS-1:0] slot_hist_r [pap2l_pkg::SLOTS];
  logic [pap2l_pkg::USED_W-1:0]       used_r;

  logic [pap2l_pkg::SLOTS-1:0]        hit;
  logic [pap2l_pkg::SLOT_W-1:0]       hit_slot;
  logic [pap2l_pkg::SLOT_W-1:0]       slot;
  logic                               found;
  logic                               full;
  logic                               fresh;
  logic [pap2l_pkg::HISTORY_BITS-1:0] hist_cur;
  logic [pap2l_pkg::HISTORY_BITS:0]   hist_shift;
  logic [pap2l_pkg::HISTORY_BITS-1:0] hist_nxt;
  logic                               upd;

  // parallel tag compare, tags are unique so an or of the hits is the slot
  always_comb begin
    hit      = '0;
    hit_slot = '0;
    for (int s = 0; s < pap2l_pkg::SLOTS; s++) begin
      hit[s] = slot_valid_r[s] && (slot_addr_r[s] == item.branch_address);
      if (hit[s]) begin
        hit_slot = hit_slot | pap2l_pkg::SLOT_W'(s);
      end
    end
  end

  // slot choice and history
  always_comb begin
    found = |hit;
    full  = (used_r == pap2l_pkg::USED_W'(pap2l_pkg::SLOTS));
    fresh = !found && !full;
    if (found) begin
      slot = hit_slot;
    end else if (fresh) begin
      slot = pap2l_pkg::SLOT_W'(used_r);
    end else begin
      slot = '0;
    end
    hist_cur   = fresh ? '1 : slot_hist_r[slot];
    hist_shift = {hist_cur, item.taken};
    hist_nxt   = hist_shift[pap2l_pkg::HISTORY_BITS-1:0];
    upd        = en && item_valid && (found || fresh);
  end

  assign lookup.valid     = item_valid;
  assign lookup.untracked = !found && full;
  assign lookup.fresh     = fresh;
  assign lookup.taken     = item.taken;
  assign lookup.idx       = {slot, hist_cur};

  // tag, valid and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      used_r       <= '0;
    end else if (upd && fresh) begin
      slot_valid_r[slot] <= 1'b1;
      used_r             <= used_r + pap2l_pkg::USED_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (upd && fresh) begin
      slot_addr_r[slot] <= item.branch_address;
    end
  end

  // per-slot history, reset to all ones
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < pap2l_pkg::SLOTS; s++) begin
        slot_hist_r[s] <= '1;
      end
    end else if (upd) begin
      slot_hist_r[slot] <= hist_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pap2l_counter_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pap2l_counter_bank (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire pap2l_pkg::lookup_t lookup,
  output logic                    clearing,
  output pap2l_pkg::result_t      result
);

  logic [1:0] ctr_mem [pap2l_pkg::CTR_DEPTH];

  logic                         clr_active_r;
  logic [pap2l_pkg::CTR_AW-1:0] clr_idx_r;

  logic [1:0]                   rd_r;
  logic                         s2_valid_r;
  logic                         s2_untr_r;
  logic                         s2_fresh_r;
  logic                         s2_taken_r;
  logic [pap2l_pkg::CTR_AW-1:0] s2_idx_r;
  logic                         s2_fwd_r;
  logic [1:0]                   s2_fwd_val_r;

  logic [1:0] ctr_cur;
  logic [1:0] ctr_nxt;
  logic       wr_en;

  // clearing sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      if (clr_idx_r == pap2l_pkg::CTR_AW'(pap2l_pkg::CTR_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + pap2l_pkg::CTR_AW'(1);
    end
  end

  assign clearing = clr_active_r;

  // counter value with bypass of the write in flight, then saturating step
  always_comb begin
    ctr_cur = s2_fwd_r ? s2_fwd_val_r : rd_r;
    ctr_nxt = ctr_cur;
    if (s2_taken_r) begin
      if (ctr_cur != pap2l_pkg::CTR_MAX) begin
        ctr_nxt = ctr_cur + 2'd1;
      end
    end else begin
      if (ctr_cur != pap2l_pkg::CTR_MIN) begin
        ctr_nxt = ctr_cur - 2'd1;
      end
    end
    wr_en = en && s2_valid_r && !s2_untr_r;
  end

  // counter memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      ctr_mem[clr_idx_r] <= pap2l_pkg::CTR_INIT;
    end else if (wr_en) begin
      ctr_mem[s2_idx_r] <= ctr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r <= ctr_mem[lookup.idx];
    end
  end

  // counter stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= lookup.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_untr_r    <= lookup.untracked;
      s2_fresh_r   <= lookup.fresh;
      s2_taken_r   <= lookup.taken;
      s2_idx_r     <= lookup.idx;
      s2_fwd_r     <= s2_valid_r && !s2_untr_r && (lookup.idx == s2_idx_r);
      s2_fwd_val_r <= ctr_nxt;
    end
  end

  assign result.valid     = s2_valid_r;
  assign result.untracked = s2_untr_r;
  assign result.fresh     = s2_fresh_r && !s2_untr_r;
  assign result.pred      = ctr_cur[1] && !s2_untr_r;
  assign result.ok        = (ctr_cur[1] == s2_taken_r) && !s2_untr_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pap2l_stats.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pap2l_stats (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire pap2l_pkg::result_t result,
  output logic                    out_valid,
  output pap2l_pkg::out_item_t    out_data
);

  logic [31:0]          correct_cnt_r;
  logic [31:0]          branch_cnt_r;
  logic [31:0]          correct_cnt_nxt;
  logic [31:0]          branch_cnt_nxt;
  logic                 out_valid_r;
  pap2l_pkg::out_item_t out_r;
  logic                 tracked;

  // saturating totals
  always_comb begin
    tracked         = result.valid && !result.untracked;
    correct_cnt_nxt = correct_cnt_r;
    branch_cnt_nxt  = branch_cnt_r;
    if (tracked && result.ok && (correct_cnt_r != pap2l_pkg::CNT_MAX)) begin
      correct_cnt_nxt = correct_cnt_r + 32'd1;
    end
    if (tracked && (branch_cnt_r != pap2l_pkg::CNT_MAX)) begin
      branch_cnt_nxt = branch_cnt_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      correct_cnt_r <= '0;
      branch_cnt_r  <= '0;
      out_valid_r   <= 1'b0;
    end else if (en) begin
      correct_cnt_r <= correct_cnt_nxt;
      branch_cnt_r  <= branch_cnt_nxt;
      out_valid_r   <= result.valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en && result.valid) begin
      out_r.predicted_taken <= result.pred;
      out_r.correct         <= result.ok;
      out_r.newly_allocated <= result.fresh;
      out_r.untracked       <= result.untracked;
      out_r.correct_total   <= correct_cnt_nxt;
      out_r.branch_total    <= branch_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pap_two_level_branch_predictor.sv =====
// channel | direction | handshake           | payload
// in_     | input     | in_valid, in_stall  | in_data  (branch_address, taken)
// out_    | output    | out_valid, out_stall| out_data (prediction, flags, totals)
//
// one branch per cycle unless stalled; beats pass input, counter and result regs
// the pace is set by the counter memory: one read and one write each cycle,
// with a bypass when back-to-back branches hit the same counter
// after reset a clearing sweep over the SLOTS * 2^HISTORY_BITS counters (4096)
// sets every counter to weakly taken; in_stall stays high through it
// out_stall on a valid result freezes the whole pipeline, and in_stall follows it
`timescale 1ns / 1ps
`default_nettype none

module pap_two_level_branch_predictor (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pap2l_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pap2l_pkg::out_item_t      out_data
);

  logic                en;
  logic                clearing;
  logic                s1_valid_r;
  pap2l_pkg::in_item_t s1_item_r;
  pap2l_pkg::lookup_t  lookup;
  pap2l_pkg::result_t  result;

  // pipeline advances whenever the result register can move
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en || clearing;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  pap2l_slot_table u_slots (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .lookup     (lookup)
  );

  pap2l_counter_bank u_ctrs (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .lookup   (lookup),
    .clearing (clearing),
    .result   (result)
  );

  pap2l_stats u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .result    (result),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pap2l_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "pap_two_level_branch_predictor_macros.svh"

module pap2l_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire pap2l_pkg::in_item_t  in_data,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire pap2l_pkg::out_item_t out_data
);

  // any prediction flag raised on the result beat
  logic flags_any;

  assign flags_any = out_data.predicted_taken | out_data.correct | out_data.newly_allocated;

  // a held input beat keeps its contents
  `PAP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

  // a held result beat keeps its contents
  `PAP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // an untracked branch carries no prediction flags
  `PAP_ASSERT_NOW(a_untracked_quiet, out_valid && out_data.untracked, !flags_any)

  // correct total never passes branch total
  `PAP_ASSERT_NOW(a_totals_order, out_valid, out_data.correct_total <= out_data.branch_total)

  // counter sweep holds off input right after reset
  `PAP_ASSERT_ALWAYS_NEXT(a_reset_stall, !rst_n, in_stall && !out_valid)

endmodule

bind pap_two_level_branch_predictor pap2l_checker u_pap2l_checker (.*);

`default_nettype wire
